/* sv/x86e_pkg.sv */
// shared types, opcode constants and mode codes for the x86 instruction byte encoder
package x86e_pkg;

    localparam int MAX_BYTES      = 8;
    localparam int POS_W          = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [7:0] code_t;

    typedef enum logic [3:0] {
        MODE_ZERO  = 4'd0,
        MODE_MOVRI = 4'd1,
        MODE_MOVSI = 4'd2,
        MODE_MOVRR = 4'd3,
        MODE_MOVRS = 4'd4,
        MODE_MOVSR = 4'd5,
        MODE_ADD   = 4'd6,
        MODE_AND   = 4'd7,
        MODE_SHR   = 4'd8,
        MODE_SHL   = 4'd9,
        MODE_CMP   = 4'd10,
        MODE_JCC   = 4'd11
    } mode_t;

    localparam code_t PFX_B      = 8'h41;
    localparam code_t PFX_R      = 8'h44;
    localparam code_t PFX_RB     = 8'h45;
    localparam code_t MODRM_DISP = 8'h45;
    localparam code_t OPC_ADSZ   = 8'h67;
    localparam code_t OPC_XOR    = 8'h31;
    localparam code_t OPC_MOVI   = 8'hb8;
    localparam code_t OPC_MOVMI  = 8'hc7;
    localparam code_t OPC_LOAD   = 8'h8b;
    localparam code_t OPC_STORE  = 8'h89;
    localparam code_t OPC_ADD    = 8'h01;
    localparam code_t OPC_AND    = 8'h21;
    localparam code_t OPC_CMP    = 8'h39;
    localparam code_t OPC_SHIFT  = 8'hc1;
    localparam code_t OPC_ESC    = 8'h0f;
    localparam code_t OPC_JE     = 8'h84;
    localparam code_t OPC_JNE    = 8'h85;
    localparam logic [2:0] EXT_SHR = 3'd5;
    localparam logic [2:0] EXT_SHL = 3'd4;
    localparam logic [31:0] JCC_LEN = 32'd6;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [15:0] immediate;
        logic [7:0]  stack_slot;
        logic        jump_if_equal;
        logic [31:0] jump_target;
        logic        body_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } out_item_t;

    // one encoded instruction: bytes[0] goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [POS_W-1:0]          len_m1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* sv/x86e_front.sv */
// front end: accepts instructions, keeps the body offset and encodes the byte list
module x86e_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  x86e_pkg::in_item_t s_item,
    input  x86e_pkg::q_status_t q_status,
    output logic               push,
    output x86e_pkg::entry_t   push_entry
);
    import x86e_pkg::*;

    logic [31:0] offset_reg, offset_next;
    logic [31:0] off_eff, rel;
    logic [3:0]  n;
    logic [MAX_BYTES-1:0][7:0] b;
    logic [2:0]  d, s;
    logic        dh, sh;
    code_t       rr_opc, rr_pfx, st_mrm, disp, sh_mrm;
    logic [2:0]  st_r;
    logic        st_h;
    logic        accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    assign d       = s_item.dest_reg[2:0];
    assign s       = s_item.src_reg[2:0];
    assign dh      = s_item.dest_reg[3];
    assign sh      = s_item.src_reg[3];
    assign off_eff = s_item.body_start ? 32'd0 : offset_reg;
    assign rel     = s_item.jump_target - off_eff - JCC_LEN;
    assign disp    = {s_item.stack_slot[5:0], 2'b00};
    assign st_r    = (s_item.mode == MODE_MOVSR) ? s : d;
    assign st_h    = (s_item.mode == MODE_MOVSR) ? sh : dh;
    assign st_mrm  = MODRM_DISP | {2'b00, st_r, 3'b000};
    assign sh_mrm  = {2'b11, (s_item.mode == MODE_SHR) ? EXT_SHR : EXT_SHL, d};
    assign rr_pfx  = (dh && sh) ? PFX_RB : (dh ? PFX_B : PFX_R);

    always_comb begin
        case (s_item.mode)
            MODE_ADD: rr_opc = OPC_ADD;
            MODE_AND: rr_opc = OPC_AND;
            MODE_CMP: rr_opc = OPC_CMP;
            default:  rr_opc = OPC_STORE;
        endcase
    end

    always_comb begin
        b = '0;
        n = 4'd0;
        case (s_item.mode)
            MODE_ZERO: begin
                if (dh) begin
                    b[0] = PFX_RB; b[1] = OPC_XOR; b[2] = {2'b11, d, d}; n = 4'd3;
                end else begin
                    b[0] = OPC_XOR; b[1] = {2'b11, d, d}; n = 4'd2;
                end
            end
            MODE_MOVRI: begin
                if (dh) begin
                    b[0] = PFX_B; b[1] = OPC_MOVI | {5'b0, d};
                    b[2] = s_item.immediate[7:0]; b[3] = s_item.immediate[15:8];
                    n = 4'd6;
                end else begin
                    b[0] = OPC_MOVI | {5'b0, d};
                    b[1] = s_item.immediate[7:0]; b[2] = s_item.immediate[15:8];
                    n = 4'd5;
                end
            end
            MODE_MOVSI: begin
                b[0] = OPC_ADSZ; b[1] = OPC_MOVMI; b[2] = MODRM_DISP; b[3] = disp;
                b[4] = s_item.immediate[7:0]; b[5] = s_item.immediate[15:8];
                n = 4'd8;
            end
            MODE_MOVRR, MODE_ADD, MODE_AND, MODE_CMP: begin
                if (dh || sh) begin
                    b[0] = rr_pfx; b[1] = rr_opc; b[2] = {2'b11, s, d}; n = 4'd3;
                end else begin
                    b[0] = rr_opc; b[1] = {2'b11, s, d}; n = 4'd2;
                end
            end
            MODE_MOVRS, MODE_MOVSR: begin
                b[0] = OPC_ADSZ;
                if (st_h) begin
                    b[1] = PFX_R;
                    b[2] = (s_item.mode == MODE_MOVSR) ? OPC_STORE : OPC_LOAD;
                    b[3] = st_mrm; b[4] = disp; n = 4'd5;
                end else begin
                    b[1] = (s_item.mode == MODE_MOVSR) ? OPC_STORE : OPC_LOAD;
                    b[2] = st_mrm; b[3] = disp; n = 4'd4;
                end
            end
            MODE_SHR, MODE_SHL: begin
                if (dh) begin
                    b[0] = PFX_B; b[1] = OPC_SHIFT; b[2] = sh_mrm;
                    b[3] = s_item.immediate[7:0]; n = 4'd4;
                end else begin
                    b[0] = OPC_SHIFT; b[1] = sh_mrm; b[2] = s_item.immediate[7:0];
                    n = 4'd3;
                end
            end
            MODE_JCC: begin
                b[0] = OPC_ESC; b[1] = s_item.jump_if_equal ? OPC_JE : OPC_JNE;
                b[2] = rel[7:0]; b[3] = rel[15:8]; b[4] = rel[23:16]; b[5] = rel[31:24];
                n = 4'd6;
            end
            default: begin
                b = '0;
                n = 4'd0;
            end
        endcase
    end

    assign offset_next       = off_eff + {28'd0, n};
    assign push              = accept && (n != 4'd0);
    assign push_entry.bytes  = b;
    assign push_entry.len_m1 = POS_W'(n - 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (accept) begin
            offset_reg <= offset_next;
        end
    end

endmodule

/* sv/x86e_queue.sv */
// short queue of encoded instructions between front and back end
module x86e_queue #(
    parameter int DEPTH = x86e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  x86e_pkg::entry_t    push_entry,
    input  logic                pop,
    output x86e_pkg::entry_t    head,
    output x86e_pkg::q_status_t q_status
);
    import x86e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* sv/x86e_back.sv */
// back end: plays out one encoded instruction a byte per cycle while m_ready is high
module x86e_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  x86e_pkg::entry_t    head,
    input  x86e_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output x86e_pkg::out_item_t m_item
);
    import x86e_pkg::*;

    entry_t           cur_reg;
    logic [POS_W-1:0] pos_reg;
    logic             valid_reg;
    logic             last, done, load;

    assign last    = (pos_reg == cur_reg.len_m1);
    assign done    = valid_reg && m_ready && last;
    assign load    = !q_status.empty && (!valid_reg || done);
    assign pop     = load;

    assign m_valid          = valid_reg;
    assign m_item.code_byte = cur_reg.bytes[pos_reg];
    assign m_item.last_byte = last;

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end else if (done) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

endmodule

/* sv/x86_instruction_byte_encoder.sv */
// top level of the x86 instruction byte encoder: front end, queue and back end
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s_      | in        | s_valid / s_ready  | s_item: one abstract instruction
//  m_      | out       | m_valid / m_ready  | m_item: one code byte, last flag
//
// an instruction is encoded in the cycle of its input transfer, is registered in
// the queue, then the back end plays out its 2 to 8 bytes, one per cycle while
// m_ready is high; the byte-wide result channel sets the sustained rate, and
// back-to-back instructions follow on the output with no gap cycle
// unused modes produce no bytes and are taken at the input only
// reset (aresetn, synchronous) clears the body offset, the queue and the output
// s_ready drops only when the queue is full; a stalled m_ready fills the queue
module x86_instruction_byte_encoder #(
    parameter int QUEUE_DEPTH = x86e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  x86e_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output x86e_pkg::out_item_t m_item
);
    import x86e_pkg::*;

    // encoded instruction handed from the front end into the queue
    entry_t    push_entry;
    entry_t    head;
    q_status_t q_status;
    logic      push, pop;

    // front end: offset bookkeeping, rel32 and the byte list for each transfer
    x86e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue so the front end keeps accepting while bytes drain
    x86e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // back end: one byte per output transfer, next entry loaded on the last one
    x86e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

/* tb/x86_instruction_byte_encoder_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the x86 instruction byte encoder
module x86_instruction_byte_encoder_tb;

    import x86e_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RESET_CYCLES   = 12;
    localparam int ITEMS_PER_MIX  = 60;
    localparam int MAX_REPORTED   = 10;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // idle and stall rates in percent, changed only between mixes
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    in_item_t    pending_instrs[$];
    out_item_t   expected_bytes[$];
    code_t       encoded_seq[$];
    logic [31:0] body_offset_model = '0;

    int unsigned instrs_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    x86_instruction_byte_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // encoding predictor: appends the bytes of one instruction to
    // encoded_seq, then turns them into expected transfers
    // ------------------------------------------------------------------
    task automatic emit_imm32(input logic [31:0] v);
        encoded_seq.push_back(v[7:0]);
        encoded_seq.push_back(v[15:8]);
        encoded_seq.push_back(v[23:16]);
        encoded_seq.push_back(v[31:24]);
    endtask

    // rex choice: B for the rm register, R for the reg field, both for both
    task automatic emit_reg_reg(input code_t opc, input logic [3:0] d, input logic [3:0] s);
        if (d[3] && s[3]) begin
            encoded_seq.push_back(PFX_RB);
        end else if (d[3]) begin
            encoded_seq.push_back(PFX_B);
        end else if (s[3]) begin
            encoded_seq.push_back(PFX_R);
        end
        encoded_seq.push_back(opc);
        encoded_seq.push_back({2'b11, s[2:0], d[2:0]});
    endtask

    // ebp-relative with disp8; displacement is 4*slot truncated, never negated
    task automatic emit_stack(input code_t opc, input logic [3:0] r, input logic [7:0] slot);
        encoded_seq.push_back(OPC_ADSZ);
        if (r[3]) begin
            encoded_seq.push_back(PFX_R);
        end
        encoded_seq.push_back(opc);
        encoded_seq.push_back(MODRM_DISP | {2'b00, r[2:0], 3'b000});
        encoded_seq.push_back({slot[5:0], 2'b00});
    endtask

    task automatic emit_shift(input logic [2:0] ext, input logic [3:0] r, input logic [15:0] imm);
        if (r[3]) begin
            encoded_seq.push_back(PFX_B);
        end
        encoded_seq.push_back(OPC_SHIFT);
        encoded_seq.push_back({2'b11, ext, r[2:0]});
        encoded_seq.push_back(imm[7:0]);
    endtask

    task automatic predict_encoding(input in_item_t it);
        out_item_t exp_byte;
        encoded_seq.delete();
        // the clear happens before the jump displacement is formed
        if (it.body_start) begin
            body_offset_model = '0;
        end
        case (it.mode)
            MODE_ZERO: begin
                if (it.dest_reg[3]) begin
                    encoded_seq.push_back(PFX_RB);
                end
                encoded_seq.push_back(OPC_XOR);
                encoded_seq.push_back({2'b11, it.dest_reg[2:0], it.dest_reg[2:0]});
            end
            MODE_MOVRI: begin
                if (it.dest_reg[3]) begin
                    encoded_seq.push_back(PFX_B);
                end
                encoded_seq.push_back(OPC_MOVI + {5'd0, it.dest_reg[2:0]});
                emit_imm32({16'd0, it.immediate});
            end
            MODE_MOVSI: begin
                encoded_seq.push_back(OPC_ADSZ);
                encoded_seq.push_back(OPC_MOVMI);
                encoded_seq.push_back(MODRM_DISP);
                encoded_seq.push_back({it.stack_slot[5:0], 2'b00});
                emit_imm32({16'd0, it.immediate});
            end
            MODE_MOVRR: emit_reg_reg(OPC_STORE, it.dest_reg, it.src_reg);
            MODE_MOVRS: emit_stack(OPC_LOAD, it.dest_reg, it.stack_slot);
            MODE_MOVSR: emit_stack(OPC_STORE, it.src_reg, it.stack_slot);
            MODE_ADD:   emit_reg_reg(OPC_ADD, it.dest_reg, it.src_reg);
            MODE_AND:   emit_reg_reg(OPC_AND, it.dest_reg, it.src_reg);
            MODE_SHR:   emit_shift(EXT_SHR, it.dest_reg, it.immediate);
            MODE_SHL:   emit_shift(EXT_SHL, it.dest_reg, it.immediate);
            MODE_CMP:   emit_reg_reg(OPC_CMP, it.dest_reg, it.src_reg);
            MODE_JCC: begin
                encoded_seq.push_back(OPC_ESC);
                encoded_seq.push_back(it.jump_if_equal ? OPC_JE : OPC_JNE);
                emit_imm32(it.jump_target - body_offset_model - JCC_LEN);
            end
            default: begin
                // unused modes emit nothing and add nothing to the offset
            end
        endcase
        foreach (encoded_seq[i]) begin
            exp_byte.code_byte = encoded_seq[i];
            exp_byte.last_byte = (i == encoded_seq.size() - 1);
            expected_bytes.push_back(exp_byte);
        end
        body_offset_model = body_offset_model + encoded_seq.size();
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t make_instr(input logic [3:0] mode, input logic [3:0] d,
                                            input logic [3:0] s, input logic [15:0] imm,
                                            input logic [7:0] slot, input logic eq,
                                            input logic [31:0] target, input logic start);
        in_item_t it;
        it.mode          = mode;
        it.dest_reg      = d;
        it.src_reg       = s;
        it.immediate     = imm;
        it.stack_slot    = slot;
        it.jump_if_equal = eq;
        it.jump_target   = target;
        it.body_start    = start;
        return it;
    endfunction

    // mostly well-formed instructions with random content, a few unused modes
    // and now and then a fresh body so jumps see small offsets again
    function automatic in_item_t random_instr();
        in_item_t it;
        it.mode          = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(12, 15))
                                                       : 4'($urandom_range(0, 11));
        it.dest_reg      = 4'($urandom_range(0, 15));
        it.src_reg       = 4'($urandom_range(0, 15));
        it.immediate     = 16'($urandom);
        it.stack_slot    = 8'($urandom);
        it.jump_if_equal = 1'($urandom);
        // jump targets mostly near the current body, sometimes anywhere
        it.jump_target   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600);
        it.body_start    = ($urandom_range(0, 99) < 8);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // driver: one nonblocking update of valid per edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_encoding(s_item);
                instrs_sent++;
            end
            // a new instruction may go out only once the current one is taken
            if (!s_valid || s_ready) begin
                if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_item  <= pending_instrs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each byte transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED) begin
                        $display("unexpected byte %02h last %0b with nothing pending",
                                 m_item.code_byte, m_item.last_byte);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_item.code_byte !== want.code_byte ||
                        m_item.last_byte !== want.last_byte) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED) begin
                            $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                     bytes_checked, want.code_byte, want.last_byte,
                                     m_item.code_byte, m_item.last_byte);
                        end
                    end
                    bytes_checked++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequencing: control variables change on the falling edge only
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_instrs.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (expected_bytes.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic queue_random_mix(input int unsigned n_items);
        in_item_t    it;
        int unsigned counted;
        counted = 0;
        // unused modes are fed but do not count towards the mix
        while (counted < n_items) begin
            it = random_instr();
            pending_instrs.push_back(it);
            if (it.mode <= MODE_JCC) begin
                counted++;
            end
        end
    endtask

    initial begin
        int unsigned mix;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: prefixes, extremes of immediates and slots, jump wrap,
        // body clears and unused modes
        pending_instrs.push_back(make_instr(MODE_ZERO,  4'd0,  4'd0,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b1));
        pending_instrs.push_back(make_instr(MODE_ZERO,  4'd15, 4'd0,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRI, 4'd0,  4'd0,  16'hffff, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRI, 4'd12, 4'd0,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVSI, 4'd0,  4'd0,  16'habcd, 8'd255, 1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVSI, 4'd0,  4'd0,  16'h8001, 8'd64,  1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRR, 4'd3,  4'd9,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRR, 4'd9,  4'd3,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRR, 4'd15, 4'd15, 16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRS, 4'd8,  4'd0,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVRS, 4'd2,  4'd0,  16'h0000, 8'd63,  1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_MOVSR, 4'd0,  4'd11, 16'h0000, 8'd200, 1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_ADD,   4'd0,  4'd0,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_AND,   4'd7,  4'd8,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_SHR,   4'd15, 4'd0,  16'h01ff, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_SHL,   4'd1,  4'd0,  16'hff20, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_CMP,   4'd10, 4'd5,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        // backward jump to zero wraps the displacement negative
        pending_instrs.push_back(make_instr(MODE_JCC,   4'd0,  4'd0,  16'h0000, 8'd0,   1'b1, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(MODE_JCC,   4'd0,  4'd0,  16'h0000, 8'd0,   1'b0, 32'hffffffff, 1'b0));
        // unused modes, one of them clearing the body offset
        pending_instrs.push_back(make_instr(4'd12,      4'd0,  4'd0,  16'h0000, 8'd0,   1'b0, 32'd0, 1'b0));
        pending_instrs.push_back(make_instr(4'd15,      4'd15, 4'd15, 16'hffff, 8'd255, 1'b1, 32'hffffffff, 1'b1));
        // jump right after the clear: displacement from a zero offset
        pending_instrs.push_back(make_instr(MODE_JCC,   4'd0,  4'd0,  16'h0000, 8'd0,   1'b1, 32'd6, 1'b0));
        pending_instrs.push_back(make_instr(MODE_JCC,   4'd0,  4'd0,  16'h0000, 8'd0,   1'b0, 32'd100, 1'b0));
        wait_drained();

        // random mixes: free flowing, slow sender, slow receiver, both slightly
        for (mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            queue_random_mix(ITEMS_PER_MIX / 2);
            if (mix == 2) begin
                // sender holds back until every queued byte has come out
                wait_drained();
            end
            queue_random_mix(ITEMS_PER_MIX - ITEMS_PER_MIX / 2);
            wait_drained();
        end

        // let any trailing zero-byte instruction retire
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            mismatch_count++;
        end

        $display("encoded %0d instructions into %0d checked code bytes, %0d mismatches",
                 instrs_sent, bytes_checked, mismatch_count);
        $display("mixes ran with free flow, sender idling, receiver stalling and both");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
